// File: sv/bdc_pkg.sv
package bdc_pkg;

  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd24;

  localparam logic [13:0] EMPTY_CHAR = 14'h2800;

  // braille dot order, indexed by {local y, local x}
  function automatic logic [7:0] dot_bit(input logic [2:0] local_pos);
    logic [7:0] bits;
    case (local_pos)
      3'd0: bits = 8'h01;
      3'd1: bits = 8'h08;
      3'd2: bits = 8'h02;
      3'd3: bits = 8'h10;
      3'd4: bits = 8'h04;
      3'd5: bits = 8'h20;
      3'd6: bits = 8'h40;
      3'd7: bits = 8'h80;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

endpackage

// File: sv/bdc_ram.sv
module bdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/braille_dot_canvas_unit.sv
// channel  dir  signals                   tdata / data fields (lsb first)
// s_axis   in   s_tvalid s_tready s_tdata operation[1:0] x_pos[11:2] y_pos[21:12]
// m_axis   out  m_tvalid m_tready m_tdata dropped[0] code_point[14:1] non_empty[15]
// cfg      in   cfg_we cfg_addr cfg_wdata 0 cols_in_use, 1 rows_in_use
//
// plot and read: cell memory read, then write back and result,
//   one transaction at a time
// clear: accept, then sweep the cell memory one cell a cycle, then result
// reset runs the same sweep with s_tready low
// a stalled result holds the block in its last step; the next input is taken after
module braille_dot_canvas_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // operation, x_pos, y_pos
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // dropped, code_point, non_empty
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  logic          clr_reply;
  logic [1:0]    op_q;
  logic          drop_q;
  logic [7:0]    mask_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    cols_in_use;
  logic [6:0]    rows_in_use;

  logic          in_take;
  logic [1:0]    in_op;
  logic          x_neg;
  logic          y_neg;
  logic [8:0]    xm;
  logic [8:0]    ym;
  logic [8:0]    col;
  logic [8:0]    row;
  logic          col_ok;
  logic          row_ok;
  logic          in_drop;
  logic [7:0]    in_mask;
  logic [AW-1:0] in_addr;

  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          res_drop;
  logic [13:0]   res_code;
  logic          res_nonempty;

  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    in_op = s_tdata[1:0];
    x_neg = s_tdata[11];
    y_neg = s_tdata[21];
    xm    = s_tdata[10:2];
    ym    = s_tdata[20:12];
    if (in_op == bdc_pkg::OP_PLOT) begin
      col = {1'b0, xm[8:1]};
      row = {2'b0, ym[8:2]};
    end else begin
      col = xm;
      row = ym;
    end
    col_ok  = ({2'b0, col} < {3'b0, cols_in_use}) && ({2'b0, col} < 11'(MAX_COLS));
    row_ok  = ({2'b0, row} < {4'b0, rows_in_use}) && ({2'b0, row} < 11'(MAX_ROWS));
    in_drop = x_neg || y_neg || !col_ok || !row_ok;
    in_mask = bdc_pkg::dot_bit({ym[1:0], xm[0]});
    in_addr = AW'(32'(row) * MAX_COLS + 32'(col));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = ram_rdata | mask_q;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else if (state == S_EXEC) begin
      ram_we = out_free && (op_q == bdc_pkg::OP_PLOT) && !drop_q;
    end
  end

  always_comb begin
    res_drop     = drop_q;
    res_code     = 14'd0;
    res_nonempty = 1'b0;
    if ((op_q == bdc_pkg::OP_READ) && !drop_q) begin
      res_code     = bdc_pkg::EMPTY_CHAR | {6'd0, ram_rdata};
      res_nonempty = |ram_rdata;
    end
  end

  bdc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_take),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= bdc_pkg::COLS_RESET;
      rows_in_use <= bdc_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        bdc_pkg::REG_COLS: cols_in_use <= cfg_wdata;
        bdc_pkg::REG_ROWS: rows_in_use <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if ((state == S_EXEC) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_op == bdc_pkg::OP_CLEAR) begin
              state     <= S_CLEAR;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= clr_reply ? S_EXEC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q   <= in_op;
      drop_q <= ((in_op == bdc_pkg::OP_PLOT) || (in_op == bdc_pkg::OP_READ)) && in_drop;
      mask_q <= in_mask;
      addr_q <= in_addr;
    end
    if ((state == S_EXEC) && out_free) begin
      m_tdata <= {res_nonempty, res_code, res_drop};
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CANVAS_COLS = 128;
  localparam int CANVAS_ROWS = 64;
  localparam logic [1:0] OP_NONE = 2'd3;
  // braille dot bits, byte i for local position {y[1:0], x[0]} == i
  localparam logic [63:0] DOT_ORDER = 64'h8040_2004_1002_0801;
  localparam int REPORT_LIMIT = 10;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SIZE_PHASES = 10;

  typedef struct packed {
    logic        non_empty;
    logic [13:0] code_point;
    logic        dropped;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // operation, x_pos, y_pos
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // dropped, code_point, non_empty
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  logic [7:0]   canvas_cells [CANVAS_COLS*CANVAS_ROWS];
  logic [7:0]   cols_model;
  logic [6:0]   rows_model;
  cell_result_t cell_results_q[$];

  int fail_count = 0;
  int checked_count = 0;
  int plot_count = 0;
  int read_count = 0;
  int clear_count = 0;
  int drop_count = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;
  int last_col = 0;
  int last_row = 0;

  braille_dot_canvas_unit #(
    .MAX_COLS(CANVAS_COLS),
    .MAX_ROWS(CANVAS_ROWS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int visible_cols();
    return (cols_model > CANVAS_COLS) ? CANVAS_COLS : int'(cols_model);
  endfunction

  function automatic int visible_rows();
    return (rows_model > CANVAS_ROWS) ? CANVAS_ROWS : int'(rows_model);
  endfunction

  function automatic void clear_canvas();
    foreach (canvas_cells[i]) canvas_cells[i] = '0;
  endfunction

  function automatic cell_result_t apply_item(logic [1:0] op, logic [9:0] x, logic [9:0] y);
    cell_result_t res;
    logic         off_canvas;
    int           col;
    int           row;
    int           dot;
    logic [7:0]   dots;
    res = '0;
    off_canvas = x[9] | y[9];
    case (op)
      bdc_pkg::OP_PLOT: begin
        col = int'(x[8:1]);
        row = int'(y[8:2]);
        if (off_canvas || col >= visible_cols() || row >= visible_rows()) begin
          res.dropped = 1'b1;
        end else begin
          dot = int'({y[1:0], x[0]});
          canvas_cells[row*CANVAS_COLS + col] |= DOT_ORDER[dot*8 +: 8];
        end
      end
      bdc_pkg::OP_READ: begin
        col = int'(x[8:0]);
        row = int'(y[8:0]);
        if (off_canvas || col >= visible_cols() || row >= visible_rows()) begin
          res.dropped = 1'b1;
        end else begin
          dots = canvas_cells[row*CANVAS_COLS + col];
          res.code_point = bdc_pkg::EMPTY_CHAR | {6'd0, dots};
          res.non_empty = (dots != 8'd0);
        end
      end
      bdc_pkg::OP_CLEAR: clear_canvas();
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [1:0] op, input int x, input int y);
    int           gap;
    cell_result_t res;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, y[9:0], x[9:0], op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = apply_item(op, x[9:0], y[9:0]);
    cell_results_q.push_back(res);
    case (op)
      bdc_pkg::OP_PLOT:  plot_count++;
      bdc_pkg::OP_READ:  read_count++;
      bdc_pkg::OP_CLEAR: clear_count++;
      default: ;
    endcase
    if (res.dropped) drop_count++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (cell_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == bdc_pkg::REG_COLS) begin
      cols_model = value;
    end else begin
      rows_model = value[6:0];
    end
  endtask

  task automatic send_random_item();
    int         pick;
    int         ec;
    int         er;
    int         x;
    int         y;
    logic [1:0] op;
    ec = visible_cols();
    er = visible_rows();
    pick = $urandom_range(0, 999);
    x = $urandom;
    y = $urandom;
    op = ($urandom_range(0, 1) == 0) ? bdc_pkg::OP_PLOT : bdc_pkg::OP_READ;
    if (pick < 12) begin
      op = bdc_pkg::OP_CLEAR;
    end else if (pick < 40) begin
      op = OP_NONE;
    end else if (pick >= 200 && ec > 0 && er > 0) begin
      if (pick < 280) begin
        // straddle the right and bottom edges
        if (op == bdc_pkg::OP_PLOT) begin
          x = 2*ec - 2 + $urandom_range(0, 3);
          y = 4*er - 4 + $urandom_range(0, 7);
        end else begin
          x = ec - 1 + $urandom_range(0, 1);
          y = er - 1 + $urandom_range(0, 1);
        end
      end else if (pick < 650) begin
        op = bdc_pkg::OP_PLOT;
        x = $urandom_range(0, 2*ec - 1);
        y = $urandom_range(0, 4*er - 1);
        last_col = x / 2;
        last_row = y / 4;
      end else begin
        op = bdc_pkg::OP_READ;
        if ($urandom_range(0, 1) == 0) begin
          x = last_col;
          y = last_row;
        end else begin
          x = $urandom_range(0, ec - 1);
          y = $urandom_range(0, er - 1);
        end
      end
    end
    send_item(op, x, y);
  endtask

  // default 80 x 24 canvas, corners and every way out of it
  task automatic test_bounds();
    send_item(bdc_pkg::OP_READ, 0, 0);
    send_item(bdc_pkg::OP_PLOT, 0, 0);
    send_item(bdc_pkg::OP_PLOT, 159, 95);
    send_item(bdc_pkg::OP_READ, 0, 0);
    send_item(bdc_pkg::OP_READ, 79, 23);
    send_item(bdc_pkg::OP_PLOT, 160, 0);
    send_item(bdc_pkg::OP_PLOT, 0, 96);
    send_item(bdc_pkg::OP_PLOT, -1, 5);
    send_item(bdc_pkg::OP_PLOT, 511, -512);
    send_item(bdc_pkg::OP_READ, 80, 0);
    send_item(bdc_pkg::OP_READ, 0, 24);
    send_item(bdc_pkg::OP_READ, -512, 511);
  endtask

  task automatic test_dot_order();
    for (int d = 0; d < 8; d++) begin
      send_item(bdc_pkg::OP_PLOT, 20 + d % 2, 20 + d / 2);
      if (d == 3 || d == 7) send_item(bdc_pkg::OP_READ, 10, 5);
    end
  endtask

  task automatic test_clear();
    send_item(OP_NONE, -1, -1);
    send_item(bdc_pkg::OP_CLEAR, 0, 0);
    send_item(bdc_pkg::OP_READ, 10, 5);
  endtask

  task automatic test_canvas_sizes();
    for (int phase = 0; phase < SIZE_PHASES; phase++) begin
      case (phase)
        1: write_reg(bdc_pkg::REG_COLS, 8'd0);
        2: begin
          write_reg(bdc_pkg::REG_COLS, 8'd255);
          write_reg(bdc_pkg::REG_ROWS, 8'd127);
        end
        3: begin
          write_reg(bdc_pkg::REG_COLS, 8'd1);
          write_reg(bdc_pkg::REG_ROWS, 8'd1);
        end
        4: begin
          write_reg(bdc_pkg::REG_COLS, 8'd128);
          write_reg(bdc_pkg::REG_ROWS, 8'd64);
        end
        5: write_reg(bdc_pkg::REG_ROWS, 8'd0);
        6: begin
          write_reg(bdc_pkg::REG_COLS, 8'd129);
          write_reg(bdc_pkg::REG_ROWS, 8'd65);
        end
        7: begin
          write_reg(bdc_pkg::REG_COLS, 8'd12);
          write_reg(bdc_pkg::REG_ROWS, 8'd3);
        end
        8: begin
          write_reg(bdc_pkg::REG_COLS, 8'($urandom_range(1, 128)));
          write_reg(bdc_pkg::REG_ROWS, 8'($urandom_range(1, 64)));
        end
        9: begin
          write_reg(bdc_pkg::REG_COLS, bdc_pkg::COLS_RESET);
          write_reg(bdc_pkg::REG_ROWS, {1'b0, bdc_pkg::ROWS_RESET});
        end
        default: ;
      endcase
      for (int n = 0; n < RANDOM_ITEMS / SIZE_PHASES; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      hold_cycles <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t got;
    cell_result_t want;
    got = m_tdata;
    if (!rst && m_tvalid && m_tready) begin
      if (cell_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result transaction %h at %0t", m_tdata, $time);
      end else begin
        want = cell_results_q.pop_front();
        checked_count++;
        if (got.dropped !== want.dropped || got.code_point !== want.code_point ||
            got.non_empty !== want.non_empty) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected dropped=%0b code=%h non_empty=%0b",
                     $time, want.dropped, want.code_point, want.non_empty);
            $display("  got dropped=%0b code=%h non_empty=%0b",
                     got.dropped, got.code_point, got.non_empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("braille_dot_canvas_unit verification failed");
    $finish;
  end

  initial begin
    cols_model = bdc_pkg::COLS_RESET;
    rows_model = bdc_pkg::ROWS_RESET;
    clear_canvas();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_bounds();
    test_dot_order();
    test_clear();
    test_canvas_sizes();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d plots, %0d reads, %0d clears (%0d dropped) over %0d canvas sizes",
             plot_count, read_count, clear_count, drop_count, SIZE_PHASES);
    $display("%0d results checked, %0d mismatches, %0d still outstanding",
             checked_count, fail_count, cell_results_q.size());
    if (fail_count == 0 && cell_results_q.size() == 0) begin
      $display("braille_dot_canvas_unit verification clean");
    end else begin
      $display("braille_dot_canvas_unit verification failed");
    end
    $finish;
  end

endmodule
